>>> sv/afsk_pkg.sv
// Shared types and constants for the AFSK NRZI tone modulator.
// No dependencies; imported by every module of the block except afsk_ram.
package afsk_pkg;

  localparam int PACKET_BYTES = 512;
  localparam int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // item commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS      = 2'd3;

  localparam logic [7:0]  SAMPLES_PER_BIT_RST = 8'd38;
  localparam logic [11:0] MARK_STEP_RST       = 12'd853;
  localparam logic [11:0] SPACE_STEP_RST      = 12'd1565;
  localparam logic [12:0] FRAME_BITS_RST      = 13'd0;

  typedef struct packed {
    logic [7:0]  samples_per_bit;
    logic [11:0] mark_step;
    logic [11:0] space_step;
    logic [12:0] frame_bits;
  } cfg_t;

  typedef struct packed {
    logic rf_level;
    logic busy_res;
    logic done_res;
  } res_t;

endpackage

>>> sv/afsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afsk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/afsk_core.sv
// Modulator state, packet store and per-item next-state logic.
// Depends on afsk_pkg and afsk_ram.
module afsk_core import afsk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] cmd_i,
  input  logic [8:0] byte_index_i,
  input  logic [7:0] byte_value_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [14:0] phase_q, phase_d;
  logic        space_q, space_d;
  logic [12:0] bitpos_q, bitpos_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  shift_q, shift_d;
  logic        sending_q, sending_d;
  logic        level_q, level_d;
  logic        done;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        rdata;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;
  logic [7:0]        fetched;
  logic              in_range;
  logic [9:0]        byte_addr;
  logic              sp;
  logic [7:0]        sb;
  logic [11:0]       step;
  logic [14:0]       phase_n;
  logic [7:0]        count_inc;

  assign we    = accept_i && (cmd_i == CMD_WRITE) && (int'(byte_index_i) < PACKET_BYTES);
  assign waddr = ADDR_W'(byte_index_i);
  // store is read every cycle at the byte of the next bit position
  assign raddr = ADDR_W'(bitpos_d[12:3]);

  afsk_ram #(.Width(8), .Depth(PACKET_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign byte_addr = bitpos_q[12:3];
  assign in_range  = int'(byte_addr) < PACKET_BYTES;
  assign fetched   = !in_range ? 8'd0 : (fwd_q ? fwd_data_q : rdata);

  always_comb begin
    phase_d   = phase_q;
    space_d   = space_q;
    bitpos_d  = bitpos_q;
    count_d   = count_q;
    shift_d   = shift_q;
    sending_d = sending_q;
    level_d   = level_q;
    done      = 1'b0;
    sp        = space_q;
    sb        = shift_q;
    step      = '0;
    phase_n   = '0;
    count_inc = '0;
    if (accept_i) begin
      unique case (cmd_i)
        CMD_START: begin
          phase_d   = '0;
          space_d   = 1'b0;
          bitpos_d  = '0;
          count_d   = '0;
          sending_d = 1'b1;
        end
        CMD_TICK: begin
          if (sending_q) begin
            if (bitpos_q == cfg_i.frame_bits) begin
              sending_d = 1'b0;
              done      = 1'b1;
            end else begin
              if (count_q == 8'd0) begin
                sb = (bitpos_q[2:0] == 3'd0) ? fetched : {1'b0, shift_q[7:1]};
                // NRZI: a zero bit toggles the tone
                if (!sb[0]) begin
                  sp = ~space_q;
                end
              end
              step      = sp ? cfg_i.space_step : cfg_i.mark_step;
              phase_n   = phase_q + 15'(step);
              count_inc = count_q + 8'd1;
              shift_d   = sb;
              space_d   = sp;
              phase_d   = phase_n;
              level_d   = phase_n[14];
              if (count_inc == cfg_i.samples_per_bit) begin
                count_d  = '0;
                bitpos_d = bitpos_q + 13'd1;
              end else begin
                count_d  = count_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      space_q   <= 1'b0;
      bitpos_q  <= '0;
      count_q   <= '0;
      shift_q   <= '0;
      sending_q <= 1'b0;
      level_q   <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      space_q   <= space_d;
      bitpos_q  <= bitpos_d;
      count_q   <= count_d;
      shift_q   <= shift_d;
      sending_q <= sending_d;
      level_q   <= level_d;
      // write and read of one entry at the same edge: RAM returns old data
      fwd_q     <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= byte_value_i;
  end

  assign res_o.rf_level = level_d;
  assign res_o.busy_res = sending_d;
  assign res_o.done_res = done;

endmodule

>>> sv/afsk_nrzi_tone_modulator_unit.sv
// Top level of the AFSK NRZI tone modulator: configuration registers,
// item handshake and output skid buffer. Depends on afsk_pkg and afsk_core.

// One item is taken per clock cycle while input ready is high, and each
// accepted item gives one registered result. The packet store is a 512 x 8
// synchronous RAM that is read every cycle at the byte of the upcoming bit
// position, so the byte needed at a byte boundary is already there; a byte
// write to that same entry is forwarded. A two-entry output stage (register
// plus skid) keeps the input side running while one result waits; input
// ready drops only when both entries hold results. The store has no reset:
// bytes must be written before a frame sends them.
module afsk_nrzi_tone_modulator_unit import afsk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [8:0]            byte_index_i,
  input  logic [7:0]            byte_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  rf_level_o,
  output logic                  busy_res_o,
  output logic                  done_res_o
);

  cfg_t cfg_q;
  res_t res_new;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept, drain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_bit <= SAMPLES_PER_BIT_RST;
      cfg_q.mark_step       <= MARK_STEP_RST;
      cfg_q.space_step      <= SPACE_STEP_RST;
      cfg_q.frame_bits      <= FRAME_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLES_PER_BIT: cfg_q.samples_per_bit <= cfg_wdata_i[7:0];
        CFG_MARK_STEP:       cfg_q.mark_step       <= cfg_wdata_i[11:0];
        CFG_SPACE_STEP:      cfg_q.space_step      <= cfg_wdata_i[11:0];
        CFG_FRAME_BITS:      cfg_q.frame_bits      <= cfg_wdata_i[12:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign drain      = out_valid_q && out_ready_i;

  afsk_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .byte_index_i (byte_index_i),
    .byte_value_i (byte_value_i),
    .cfg_i        (cfg_q),
    .res_o        (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (drain) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || drain) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (drain) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (drain) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || drain) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rf_level_o  = out_q.rf_level;
  assign busy_res_o  = out_q.busy_res;
  assign done_res_o  = out_q.done_res;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && accept))
    else $error("skid filled without a stalled output");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("frame end reported while still busy");

endmodule

>>> tb/sv/afsk_nrzi_tone_modulator_checker.sv
`timescale 1ns / 100ps
// Result checker for the AFSK NRZI tone modulator: follows the config port and both
// item channels, models the modulator and compares each result. Depends on afsk_pkg.
module afsk_nrzi_tone_modulator_checker import afsk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            cmd_i,
  input  logic [8:0]            byte_index_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  rf_level_i,
  input  logic                  busy_res_i,
  input  logic                  done_res_i,
  output int                    pending_o,
  output int                    errors_o,
  output int                    results_o
);

  // modulator model state
  cfg_t        regs;
  logic [7:0]  packet_mem [PACKET_BYTES];
  logic [14:0] tone_phase;
  logic        on_space;
  logic [12:0] bit_pos;
  logic [7:0]  sample_cnt;
  logic [7:0]  cur_byte;
  logic        frame_active;
  logic        level_q;

  res_t        expected_q [$];
  res_t        predicted;
  res_t        oldest;

  task automatic modulate_item(input logic [1:0] cmd, input logic [8:0] idx,
                               input logic [7:0] val, output res_t r);
    logic       done;
    logic [9:0] byte_addr;
    done = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        if (idx < PACKET_BYTES) packet_mem[idx] = val;
      end
      CMD_START: begin
        tone_phase   = '0;
        on_space     = 1'b0;
        bit_pos      = '0;
        sample_cnt   = '0;
        frame_active = 1'b1;
      end
      CMD_TICK: begin
        if (frame_active) begin
          if (bit_pos == regs.frame_bits) begin
            // frame end: no phase step on this tick
            frame_active = 1'b0;
            done         = 1'b1;
          end else begin
            if (sample_cnt == 8'd0) begin
              if (bit_pos[2:0] == 3'd0) begin
                byte_addr = bit_pos[12:3];
                cur_byte  = (byte_addr < PACKET_BYTES) ? packet_mem[byte_addr[8:0]] : 8'h00;
              end else begin
                cur_byte = cur_byte >> 1;
              end
              // NRZI: a zero bit swaps the tone
              if (!cur_byte[0]) on_space = ~on_space;
            end
            tone_phase = tone_phase + (on_space ? {3'b000, regs.space_step}
                                                : {3'b000, regs.mark_step});
            level_q    = tone_phase[14];
            sample_cnt = sample_cnt + 8'd1;
            if (sample_cnt == regs.samples_per_bit) begin
              sample_cnt = '0;
              bit_pos    = bit_pos + 13'd1;
            end
          end
        end
      end
      default: ;
    endcase
    r.rf_level = level_q;
    r.busy_res = frame_active;
    r.done_res = done;
  endtask

  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.samples_per_bit = SAMPLES_PER_BIT_RST;
      regs.mark_step       = MARK_STEP_RST;
      regs.space_step      = SPACE_STEP_RST;
      regs.frame_bits      = FRAME_BITS_RST;
      tone_phase   = '0;
      on_space     = 1'b0;
      bit_pos      = '0;
      sample_cnt   = '0;
      cur_byte     = '0;
      frame_active = 1'b0;
      level_q      = 1'b0;
      expected_q.delete();
      pending_o = 0;
      errors_o  = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SAMPLES_PER_BIT: regs.samples_per_bit = cfg_wdata_i[7:0];
          CFG_MARK_STEP:       regs.mark_step       = cfg_wdata_i[11:0];
          CFG_SPACE_STEP:      regs.space_step      = cfg_wdata_i[11:0];
          CFG_FRAME_BITS:      regs.frame_bits      = cfg_wdata_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        modulate_item(cmd_i, byte_index_i, byte_value_i, predicted);
        expected_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: result with no item pending, expected none, actual %0b/%0b/%0b",
                   $time, rf_level_i, busy_res_i, done_res_i);
        end else begin
          oldest = expected_q.pop_front();
          check_field("rf_level", oldest.rf_level, rf_level_i);
          check_field("busy_res", oldest.busy_res, busy_res_i);
          check_field("done_res", oldest.done_res, done_res_i);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> tb/sv/afsk_nrzi_tone_modulator_unit_tb.sv
`timescale 1ns / 100ps
// Top of the AFSK NRZI tone modulator testbench: clock, reset, item and config
// stimulus, output stalls, watchdog and verdict. Depends on afsk_pkg and the checker.
module afsk_nrzi_tone_modulator_unit_tb;
  import afsk_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 500;
  localparam int         RANDOM_ITEMS   = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            in_cmd = CMD_WRITE;
  logic [8:0]            in_index = '0;
  logic [7:0]            in_value = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic                  rf_level_o;
  logic                  busy_res_o;
  logic                  done_res_o;

  int checker_pending;
  int checker_errors;
  int checker_results;

  // stimulus-side view of the block
  logic [7:0]  cur_spb  = SAMPLES_PER_BIT_RST;
  logic [12:0] cur_fb   = FRAME_BITS_RST;
  logic        written [PACKET_BYTES];
  int          ticks_left = 0;
  int          items_sent = 0;
  int          frames_run = 0;
  int          idle_pct = 20;
  logic        quiet_mode = 1'b0;
  int          stall_left = 0;
  int          stuck_cycles = 0;

  afsk_nrzi_tone_modulator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .cmd_i        (in_cmd),
    .byte_index_i (in_index),
    .byte_value_i (in_value),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .rf_level_o   (rf_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o)
  );

  afsk_nrzi_tone_modulator_checker result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready_o),
    .cmd_i        (in_cmd),
    .byte_index_i (in_index),
    .byte_value_i (in_value),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready),
    .rf_level_i   (rf_level_o),
    .busy_res_i   (busy_res_o),
    .done_res_i   (done_res_o),
    .pending_o    (checker_pending),
    .errors_o     (checker_errors),
    .results_o    (checker_results)
  );

  always #5 clk_i = ~clk_i;

  // output stalls in random bursts
  always @(posedge clk_i) begin
    if (quiet_mode || !rst_ni) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int frame_ticks();
    return int'(cur_fb) * ((cur_spb == 8'd0) ? 256 : int'(cur_spb)) + 1;
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 4095;
      2:       return 0;
      default: return $urandom_range(1, 4095);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [8:0] idx,
                           input logic [7:0] val);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_index <= idx;
    in_value <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    case (cmd)
      CMD_WRITE: written[idx] = 1'b1;
      CMD_START: ticks_left = frame_ticks();
      CMD_TICK:  if (ticks_left > 0) ticks_left--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (checker_pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // caller lowers cfg_we after the last write of a group
  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_SAMPLES_PER_BIT: cur_spb = data[7:0];
      CFG_FRAME_BITS:      cur_fb  = data[12:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int spb, input int mark, input int space, input int fb);
    wait_drained();
    write_one(CFG_SAMPLES_PER_BIT, spb);
    write_one(CFG_MARK_STEP, mark);
    write_one(CFG_SPACE_STEP, space);
    write_one(CFG_FRAME_BITS, fb);
    cfg_we <= 1'b0;
  endtask

  task automatic send_noise(input int nbytes);
    logic [8:0] widx;
    widx = (nbytes > 0 && $urandom_range(0, 1) == 1) ? 9'($urandom_range(0, nbytes - 1))
                                                      : 9'($urandom_range(0, 511));
    case ($urandom_range(0, 2))
      0:       send_item(CMD_TICK, 9'($urandom), 8'($urandom));
      1:       send_item(CMD_UNUSED, 9'($urandom), 8'($urandom));
      default: send_item(CMD_WRITE, widx, 8'($urandom_range(0, 255)));
    endcase
  endtask

  // fill the bytes the frame will read, send it to the end, then poke the idle block
  task automatic run_frame(input int noise_pct);
    int nbytes;
    int restarts;
    nbytes = (int'(cur_fb) + 7) / 8;
    if (nbytes > PACKET_BYTES) nbytes = PACKET_BYTES;
    for (int i = 0; i < nbytes; i++) begin
      if (!written[i]) send_item(CMD_WRITE, 9'(i), 8'($urandom_range(0, 255)));
    end
    send_item(CMD_START, 9'($urandom), 8'($urandom));
    restarts = 0;
    while (ticks_left > 0) begin
      if ($urandom_range(0, 99) >= noise_pct) begin
        send_item(CMD_TICK, 9'($urandom), 8'($urandom));
      end else if (restarts < 2 && $urandom_range(0, 3) == 0) begin
        restarts++;
        send_item(CMD_START, 9'($urandom), 8'($urandom));
      end else begin
        send_noise(nbytes);
      end
    end
    repeat ($urandom_range(0, 3)) send_noise(nbytes);
    frames_run++;
  endtask

  initial begin
    int spb;
    int fb;
    int base;
    for (int i = 0; i < PACKET_BYTES; i++) written[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: zero-length frames, idle ticks, the unused command, restarts
    send_item(CMD_TICK, 9'h1FF, 8'hFF);
    send_item(CMD_UNUSED, 9'h000, 8'h00);
    send_item(CMD_START, 9'h000, 8'h00);
    send_item(CMD_TICK, 9'h000, 8'h00);
    send_item(CMD_TICK, 9'h155, 8'hAA);
    send_item(CMD_START, 9'h0AA, 8'h55);
    send_item(CMD_START, 9'h1FF, 8'hFF);
    send_item(CMD_TICK, 9'h000, 8'h00);
    send_item(CMD_WRITE, 9'h000, 8'h00);
    send_item(CMD_WRITE, 9'h001, 8'hFF);
    send_item(CMD_WRITE, 9'h1FF, 8'h5A);

    // one bit at the reset rate and tone steps
    wait_drained();
    write_one(CFG_FRAME_BITS, 1);
    cfg_we <= 1'b0;
    run_frame(0);

    // extreme steps, one sample per bit, all-zero then all-one byte
    program_regs(1, 4095, 1, 12);
    run_frame(0);

    // 256-tick bit from a zero setting
    program_regs(0, 4095, 1, 1);
    run_frame(5);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: spb = $urandom_range(1, 3);
        6, 7, 8:          spb = $urandom_range(4, 12);
        default:          spb = $urandom_range(13, 255);
      endcase
      // keep each frame short
      fb = $urandom_range(0, 36 / spb);
      program_regs(spb, pick_step(), pick_step(), fb);
      run_frame($urandom_range(0, 30));
    end

    // closing stretch at full rate
    idle_pct   = 0;
    quiet_mode = 1'b1;
    repeat (2) begin
      program_regs($urandom_range(1, 3), pick_step(), pick_step(), $urandom_range(0, 12));
      run_frame(10);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d items in %0d frames, %0d results checked", items_sent,
             frames_run, checker_results);
    $display("Ran 256-tick bits, extreme tone steps, restarts and stalls on both sides");
    if (checker_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
